[rtl/session_semaphore_locks_assert.svh]
// assertion macros for the semaphore lock bank
// depends on nothing; included by the top level
`ifndef SESSION_SEMAPHORE_LOCKS_ASSERT_SVH
`define SESSION_SEMAPHORE_LOCKS_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define SSL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// next-cycle implication, checked out of reset
`define SSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define SSL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SSL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/ssl_pkg.sv]
// shared types and constants for the semaphore lock bank
// no dependencies; used by ssl_lock_bank and session_semaphore_locks
package ssl_pkg;

  localparam int LOCK_COUNT_DEF = 4;
  localparam int SESSION_W      = 64;
  localparam int COUNT_W        = 32;

  // operation codes
  localparam logic [2:0] OP_ACQUIRE    = 3'd0;
  localparam logic [2:0] OP_FREE       = 3'd1;
  localparam logic [2:0] OP_READ_COUNT = 3'd2;
  localparam logic [2:0] OP_QUERY_HELD = 3'd3;
  localparam logic [2:0] OP_CLEANUP    = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_HELD      = 2'd1;
  localparam logic [1:0] STAT_NOT_OWNER = 2'd2;

  typedef struct packed {
    logic [2:0]           op;
    logic [1:0]           lock_index;
    logic [SESSION_W-1:0] session_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] count_value;
    logic               is_held;
  } out_item_t;

  // update strobes into the lock bank
  typedef struct packed {
    logic acquire;
    logic release_lock;
  } bank_ctl_t;

  // contents of the selected lock
  typedef struct packed {
    logic                 held;
    logic [COUNT_W-1:0]   count;
    logic [SESSION_W-1:0] owner;
  } bank_rd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OP,
    S_SCAN
  } ssl_state_t;

endpackage

[rtl/session_semaphore_locks.sv]
// Bank of LOCK_COUNT semaphore locks with acquire, free, read-counter,
// query-held and session-cleanup requests. A request is accepted in S_IDLE
// and executed in S_OP, which loads the result register; a cleanup request
// instead walks the locks in S_SCAN, because a single 64-bit owner
// comparator walks the locks one per cycle. in_ready is high only between
// requests; the result sits in an output register, and the last step of a
// request waits while an earlier result has not been taken.
// depends on ssl_pkg, ssl_lock_bank and session_semaphore_locks_assert.svh
`include "session_semaphore_locks_assert.svh"

module session_semaphore_locks #(
  parameter int LOCK_COUNT = ssl_pkg::LOCK_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ssl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ssl_pkg::out_item_t out_data
);

  localparam int IDX_W = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;

  ssl_pkg::ssl_state_t state_r, state_nxt;
  ssl_pkg::in_item_t   req_r, req_nxt;
  logic [IDX_W-1:0]    cur_idx_r, cur_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  ssl_pkg::out_item_t  out_data_r, out_data_nxt;

  ssl_pkg::bank_ctl_t  ctl;
  ssl_pkg::bank_rd_t   rd;
  logic                owner_match;
  logic                idx_ok;
  logic                op_known;
  logic                out_free;
  logic                last_lock;

  ssl_lock_bank #(
    .LOCK_COUNT(LOCK_COUNT)
  ) u_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .idx       (cur_idx_r),
    .ctl       (ctl),
    .session_id(req_r.session_id),
    .rd        (rd)
  );

  // shared owner comparator
  assign owner_match = (rd.owner == req_r.session_id);

  assign idx_ok    = (32'(req_r.lock_index) < LOCK_COUNT);
  assign op_known  = (req_r.op <= ssl_pkg::OP_QUERY_HELD);
  assign out_free  = !out_valid_r || out_ready;
  assign last_lock = (cur_idx_r == IDX_W'(LOCK_COUNT - 1));

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssl_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    cur_idx_r  <= cur_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cur_idx_nxt   = cur_idx_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctl           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ssl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt = in_data;
          if (in_data.op == ssl_pkg::OP_CLEANUP) begin
            cur_idx_nxt = '0;
            state_nxt   = ssl_pkg::S_SCAN;
          end else begin
            cur_idx_nxt = IDX_W'(in_data.lock_index);
            state_nxt   = ssl_pkg::S_OP;
          end
        end
      end
      ssl_pkg::S_OP: begin
        if (out_free) begin
          out_data_nxt  = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = ssl_pkg::S_IDLE;
          if (op_known && idx_ok) begin
            out_data_nxt.count_value = rd.count;
            out_data_nxt.is_held     = rd.held;
            // acquire fails on a held lock
            if (req_r.op == ssl_pkg::OP_ACQUIRE) begin
              if (rd.held) begin
                out_data_nxt.status = ssl_pkg::STAT_HELD;
              end else begin
                ctl.acquire = 1'b1;
              end
            end else if (req_r.op == ssl_pkg::OP_FREE) begin
              // only the recorded owner may free
              if (owner_match) begin
                ctl.release_lock = 1'b1;
              end else begin
                out_data_nxt.status = ssl_pkg::STAT_NOT_OWNER;
              end
            end
          end
        end
      end
      ssl_pkg::S_SCAN: begin
        // release this lock if the session holds it
        if (!last_lock || out_free) begin
          ctl.release_lock = rd.held && owner_match;
          if (last_lock) begin
            out_data_nxt  = '0;
            out_valid_nxt = 1'b1;
            state_nxt     = ssl_pkg::S_IDLE;
          end else begin
            cur_idx_nxt = cur_idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ssl_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `SSL_ASSERT_IMPL(a_held_fail_reports_held, clk, rst_n,
    out_valid_r && (out_data_r.status == ssl_pkg::STAT_HELD), out_data_r.is_held)
  `SSL_ASSERT_IMPL(a_status_defined, clk, rst_n, out_valid_r,
    (out_data_r.status == ssl_pkg::STAT_OK) ||
    (out_data_r.status == ssl_pkg::STAT_HELD) ||
    (out_data_r.status == ssl_pkg::STAT_NOT_OWNER))
  `SSL_ASSERT_IMPL(a_scan_in_range, clk, rst_n, state_r == ssl_pkg::S_SCAN,
    32'(cur_idx_r) < LOCK_COUNT)
  `SSL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

[rtl/ssl_lock_bank.sv]
// lock storage: held flags, acquisition counters and owner ids
// depends on ssl_pkg
module ssl_lock_bank #(
  parameter int  LOCK_COUNT = ssl_pkg::LOCK_COUNT_DEF,
  localparam int IDX_W      = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [IDX_W-1:0]                idx,
  input  ssl_pkg::bank_ctl_t              ctl,
  input  logic [ssl_pkg::SESSION_W-1:0]   session_id,
  output ssl_pkg::bank_rd_t               rd
);

  logic                          held_r  [LOCK_COUNT];
  logic [ssl_pkg::COUNT_W-1:0]   count_r [LOCK_COUNT];
  logic [ssl_pkg::SESSION_W-1:0] owner_r [LOCK_COUNT];
  logic                          idx_ok;

  assign idx_ok = (32'(idx) < LOCK_COUNT);

  // single read port at the selected lock
  always_comb begin
    rd = '0;
    if (idx_ok) begin
      rd.held  = held_r[idx];
      rd.count = count_r[idx];
      rd.owner = owner_r[idx];
    end
  end

  // update the selected lock
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LOCK_COUNT; i++) begin
        held_r[i]  <= 1'b0;
        count_r[i] <= '0;
        owner_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < LOCK_COUNT; i++) begin
        if (IDX_W'(i) == idx) begin
          if (ctl.acquire) begin
            held_r[i]  <= 1'b1;
            count_r[i] <= count_r[i] + 1'b1;
            owner_r[i] <= session_id;
          end else if (ctl.release_lock) begin
            held_r[i] <= 1'b0;
          end
        end
      end
    end
  end

endmodule

[tb/sv/ssl_lock_checker.sv]
// request/result checker for the semaphore lock bank: keeps its own copy of the
// locks, predicts each result and compares it with what the block returns
// depends on ssl_pkg
`timescale 1ns / 1ps

module ssl_lock_checker #(
  parameter int LOCK_COUNT = ssl_pkg::LOCK_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  ssl_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  ssl_pkg::out_item_t out_data,
  output int                 results_owed,
  output int                 mismatch_count
);

  // shadow copy of the lock bank
  logic                          lock_held  [LOCK_COUNT];
  logic [ssl_pkg::COUNT_W-1:0]   lock_grants[LOCK_COUNT];
  logic [ssl_pkg::SESSION_W-1:0] lock_owner [LOCK_COUNT];

  ssl_pkg::out_item_t owed_results[$];
  int                 mismatches = 0;

  assign mismatch_count = mismatches;

  // apply one request to the shadow locks and return the result it should give
  function automatic ssl_pkg::out_item_t apply_lock_request(ssl_pkg::in_item_t req);
    ssl_pkg::out_item_t res;
    int                 idx;
    res = '0;
    idx = int'(req.lock_index);
    if (req.op == ssl_pkg::OP_CLEANUP) begin
      for (int i = 0; i < LOCK_COUNT; i++) begin
        if (lock_held[i] && lock_owner[i] == req.session_id) lock_held[i] = 1'b0;
      end
    end else if (req.op <= ssl_pkg::OP_QUERY_HELD && idx < LOCK_COUNT) begin
      res.count_value = lock_grants[idx];
      res.is_held     = lock_held[idx];
      case (req.op)
        ssl_pkg::OP_ACQUIRE: begin
          if (lock_held[idx]) begin
            res.status = ssl_pkg::STAT_HELD;
          end else begin
            lock_held[idx]   = 1'b1;
            lock_grants[idx] = lock_grants[idx] + 1'b1;
            lock_owner[idx]  = req.session_id;
          end
        end
        ssl_pkg::OP_FREE: begin
          // owner id survives a free, so the same session may free again
          if (lock_owner[idx] == req.session_id) lock_held[idx] = 1'b0;
          else res.status = ssl_pkg::STAT_NOT_OWNER;
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // results are checked before new requests are queued at the same edge
  always @(posedge clk) begin
    ssl_pkg::out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < LOCK_COUNT; i++) begin
        lock_held[i]   = 1'b0;
        lock_grants[i] = '0;
        lock_owner[i]  = '0;
      end
      owed_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result with no request pending, expected none actual %0h",
                   $time, out_data);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          check_field("status", 64'(want.status), 64'(out_data.status));
          check_field("count_value", 64'(want.count_value), 64'(out_data.count_value));
          check_field("is_held", 64'(want.is_held), 64'(out_data.is_held));
        end
      end
      if (in_valid && in_ready) owed_results.push_back(apply_lock_request(in_data));
    end
    results_owed <= owed_results.size();
  end

endmodule

[tb/sv/session_semaphore_locks_test.sv]
// top of the semaphore lock bank test: clock, reset, request stimulus, result
// stalls, cycle watchdog and verdict; depends on ssl_pkg, ssl_lock_checker and
// the session_semaphore_locks block
`timescale 1ns / 1ps

module session_semaphore_locks_test;

  localparam int REQUEST_TARGET = 1300;
  localparam int CALM_TAIL      = 150;
  localparam int STALL_LIMIT    = 4000;
  localparam logic [ssl_pkg::SESSION_W-1:0] SESS_ONES = '1;
  localparam logic [ssl_pkg::SESSION_W-1:0] SESS_ALT  = 64'hA5A5_5A5A_0F0F_F0F0;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               out_ready = 1'b0;
  ssl_pkg::in_item_t  in_data   = '0;
  logic               in_ready;
  logic               out_valid;
  ssl_pkg::out_item_t out_data;

  int results_owed;
  int mismatch_count;
  int idle_cycles = 0;
  int sent        = 0;
  int gap_odds    = 0;
  bit calm        = 1'b0;

  logic [ssl_pkg::SESSION_W-1:0] sessions[4];

  session_semaphore_locks dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  ssl_lock_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .results_owed  (results_owed),
    .mismatch_count(mismatch_count)
  );

  always #5 clk = ~clk;

  // watchdog: too many cycles with no request and no result moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // result side: random stall bursts, none once the run has calmed down
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // present one request, hold it until taken, then maybe leave a gap
  task automatic send_request(logic [2:0] op, logic [1:0] idx,
                              logic [ssl_pkg::SESSION_W-1:0] sess);
    ssl_pkg::in_item_t req;
    req.op         = op;
    req.lock_index = idx;
    req.session_id = sess;
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // hold off new requests until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  function automatic logic [ssl_pkg::SESSION_W-1:0] wide_random();
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [ssl_pkg::SESSION_W-1:0] who;
    logic [1:0]                    lk;
    int                            pick;
    int                            mode_mark;
    bit                            paused;
    sessions[0] = '0;
    sessions[1] = SESS_ONES;
    sessions[2] = wide_random();
    sessions[3] = wide_random();
    mode_mark   = 0;
    paused      = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    gap_odds = 3;
    send_request(ssl_pkg::OP_QUERY_HELD, 2'd0, '0);
    send_request(ssl_pkg::OP_READ_COUNT, 2'd3, SESS_ONES);
    send_request(ssl_pkg::OP_FREE, 2'd1, '0);         // never-taken lock, owner is zero
    send_request(ssl_pkg::OP_FREE, 2'd2, SESS_ONES);  // refused, not owner
    send_request(ssl_pkg::OP_ACQUIRE, 2'd0, SESS_ONES);
    send_request(ssl_pkg::OP_ACQUIRE, 2'd0, SESS_ALT); // already held
    send_request(ssl_pkg::OP_FREE, 2'd0, SESS_ALT);   // refused while held by another
    send_request(ssl_pkg::OP_READ_COUNT, 2'd0, SESS_ALT);
    send_request(ssl_pkg::OP_FREE, 2'd0, SESS_ONES);
    send_request(ssl_pkg::OP_FREE, 2'd0, SESS_ONES);  // owner kept after free
    send_request(ssl_pkg::OP_ACQUIRE, 2'd3, SESS_ONES);
    send_request(ssl_pkg::OP_ACQUIRE, 2'd2, SESS_ONES);
    send_request(ssl_pkg::OP_ACQUIRE, 2'd1, SESS_ALT);
    send_request(ssl_pkg::OP_CLEANUP, 2'd3, SESS_ONES); // drops locks 2 and 3 only
    send_request(ssl_pkg::OP_QUERY_HELD, 2'd3, '0);
    send_request(ssl_pkg::OP_QUERY_HELD, 2'd1, '0);
    send_request(ssl_pkg::OP_CLEANUP, 2'd0, SESS_ALT);
    for (int k = 1; k <= 3; k++) send_request(3'(ssl_pkg::OP_CLEANUP + k), 2'd3, SESS_ONES);
    send_request(ssl_pkg::OP_ACQUIRE, 2'd0, '0);
    send_request(ssl_pkg::OP_CLEANUP, 2'd2, '0);
    send_request(ssl_pkg::OP_READ_COUNT, 2'd0, '0);
    drain_results();

    // random traffic, mostly acquire / use / release sequences
    while (sent < REQUEST_TARGET) begin
      if (sent >= REQUEST_TARGET - CALM_TAIL) calm = 1'b1;
      if (sent - mode_mark >= 64) begin
        mode_mark = sent;
        case ($urandom_range(0, 3))
          0: gap_odds = 0;
          1: gap_odds = 2;
          2: gap_odds = 4;
          default: gap_odds = 8;
        endcase
      end
      if (!paused && sent >= REQUEST_TARGET / 2) begin
        paused = 1'b1;
        drain_results();
      end

      pick = $urandom_range(0, 9);
      who  = sessions[$urandom_range(0, 3)];
      lk   = 2'($urandom_range(0, 3));
      if (pick < 8) begin
        // take a lock, look at it, contend for it, give it back
        send_request(ssl_pkg::OP_ACQUIRE, lk, who);
        if ($urandom_range(0, 1))
          send_request($urandom_range(0, 1) ? ssl_pkg::OP_READ_COUNT : ssl_pkg::OP_QUERY_HELD,
                       lk, sessions[$urandom_range(0, 3)]);
        if ($urandom_range(0, 3) == 0)
          send_request(ssl_pkg::OP_ACQUIRE, lk, sessions[$urandom_range(0, 3)]);
        if ($urandom_range(0, 3) == 0)
          send_request(ssl_pkg::OP_CLEANUP, 2'($urandom_range(0, 3)), who);
        else
          send_request(ssl_pkg::OP_FREE, lk,
                       $urandom_range(0, 4) == 0 ? sessions[$urandom_range(0, 3)] : who);
      end else begin
        // noise: any op code; stray ids never acquire so no lock gets stuck
        pick = $urandom_range(0, 7);
        if (pick != ssl_pkg::OP_ACQUIRE && $urandom_range(0, 1)) who = wide_random();
        send_request(3'(pick), lk, who);
      end

      // retire a session: release what it holds, then give the slot a new id
      if ($urandom_range(0, 49) == 0) begin
        pick = $urandom_range(2, 3);
        send_request(ssl_pkg::OP_CLEANUP, 2'($urandom_range(0, 3)), sessions[pick]);
        sessions[pick] = wide_random();
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
